@@ src/rlv_pkg.sv @@
// rlv_pkg: shared constants and types for the 3x3 local variance filter.
// No dependencies; imported by the interfaces and the top level.
package rlv_pkg;

    localparam int PIX_W      = 8;
    localparam int CH_N       = 3;
    localparam int PIXEL_W    = PIX_W * CH_N;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_WIDTH  = 3;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LW_W       = 11;
    localparam int CLR_W      = COL_W + 1;
    localparam int SUM_W      = PIX_W + 4;
    localparam int SQ_W       = 2 * PIX_W + 4;
    localparam int NQ_W       = SQ_W + 4;
    localparam int CH_SCORE_W = 21;
    localparam int SCORE_W    = 22;
    localparam int SCORE_MAX  = 3901500;

    typedef logic [PIXEL_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t upper;
        pixel_t lower;
    } line_entry_t;

    typedef struct packed {
        pixel_t             pix;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } stage1_t;

endpackage

@@ src/rlv_if.sv @@
// Request channels of the 3x3 local variance filter: pixel in, score out.
// Depends on rlv_pkg.
interface rlv_pix_if import rlv_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic               frame_start;

    modport source (output valid, red, green, blue, frame_start, input ready);
    modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface rlv_res_if import rlv_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SCORE_W-1:0]     spread_times_nine;
    logic [COL_W-1:0]       centre_column;
    logic [ROW_W-1:0]       centre_row;

    modport source (output valid, spread_times_nine, centre_column, centre_row, input ready);
    modport sink   (input valid, spread_times_nine, centre_column, centre_row, output ready);
endinterface

@@ src/rgb_local_variance_3x3.sv @@
// rgb_local_variance_3x3: streaming 3x3 RGB local variance, line memory plus window.
// Depends on rlv_pkg and the channel interfaces in rlv_if.sv.
//
//   channel   | dir | handshake             | payload
//   ----------+-----+-----------------------+-------------------------------------
//   pix_in    | in  | valid/ready           | red, green, blue, frame_start
//   res_out   | out | valid/ready           | spread_times_nine, centre_column/row
//   cfg       | in  | cfg_we                | cfg_wdata = line_width
//
// One pixel request per cycle while pix_in.ready is high; every stage below is registered.
// The line memory is read at acceptance and written back when the pixel enters the window;
// back-to-back hits on one column are forwarded.
// After reset a pass clears every line memory entry; pix_in.ready stays low meanwhile.
// Stalls on res_out fill pipeline bubbles first, then back up to pix_in.ready.
module rgb_local_variance_3x3 import rlv_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [LW_W-1:0] cfg_wdata,
    rlv_pix_if.sink         pix_in,
    rlv_res_if.source       res_out
);

    logic [LW_W-1:0]    line_width_reg;
    logic [LW_W-1:0]    width_eff;

    logic [CLR_W-1:0]   clr_cnt_reg;
    logic               clearing;

    logic [COL_W-1:0]   column_count_reg, column_count_next;
    logic [ROW_W-1:0]   row_count_reg, row_count_next;
    logic [COL_W-1:0]   col_cur;
    logic [ROW_W-1:0]   row_cur;
    logic [LW_W-1:0]    col_plus;

    line_entry_t        line_mem [MAX_WIDTH];
    logic               mem_we;
    logic [COL_W-1:0]   mem_wa;
    line_entry_t        mem_wd;

    logic               s1_valid_reg;
    stage1_t            s1_reg;
    line_entry_t        rd_reg;
    logic               fwd_valid_reg;
    line_entry_t        fwd_reg;
    pixel_t             up_eff, lo_eff;
    line_entry_t        wr_entry;

    pixel_t             win_reg [3][3];
    logic               s2_valid_reg;
    logic [COL_W-1:0]   s2_col_reg;
    logic [ROW_W-1:0]   s2_row_reg;

    logic [SUM_W-1:0]   sum_comb [CH_N];
    logic [SQ_W-1:0]    sq_comb [CH_N];
    logic               s3_valid_reg;
    logic [SUM_W-1:0]   s3_sum_reg [CH_N];
    logic [SQ_W-1:0]    s3_sq_reg [CH_N];
    logic [COL_W-1:0]   s3_col_reg;
    logic [ROW_W-1:0]   s3_row_reg;

    logic [CH_SCORE_W-1:0] ch_score_comb [CH_N];
    logic               s4_valid_reg;
    logic [CH_SCORE_W-1:0] s4_score_reg [CH_N];
    logic [COL_W-1:0]   s4_col_reg;
    logic [ROW_W-1:0]   s4_row_reg;

    logic               res_valid_reg;
    logic [SCORE_W-1:0] res_score_reg;
    logic [COL_W-1:0]   res_col_reg;
    logic [ROW_W-1:0]   res_row_reg;

    logic               free1, free2, free3, free4, free5;
    logic               accept, s1_leave;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_width_reg <= LW_W'(MAX_WIDTH);
        else if (cfg_we)
            line_width_reg <= cfg_wdata;
    end

    always_comb
    begin
        if (line_width_reg < LW_W'(MIN_WIDTH))
            width_eff = LW_W'(MIN_WIDTH);
        else if (line_width_reg > LW_W'(MAX_WIDTH))
            width_eff = LW_W'(MAX_WIDTH);
        else
            width_eff = line_width_reg;
    end

    // line memory clearing pass
    assign clearing = !clr_cnt_reg[CLR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (clearing)
            clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
    end

    // flow control
    assign free5    = !res_valid_reg || res_out.ready;
    assign free4    = !s4_valid_reg || free5;
    assign free3    = !s3_valid_reg || free4;
    assign free2    = !s2_valid_reg || free3;
    assign free1    = !s1_valid_reg || free2;
    assign pix_in.ready = free1 && !clearing;
    assign accept   = pix_in.valid && pix_in.ready;
    assign s1_leave = s1_valid_reg && free2;

    // position counters
    assign col_cur  = pix_in.frame_start ? '0 : column_count_reg;
    assign row_cur  = pix_in.frame_start ? '0 : row_count_reg;
    assign col_plus = {1'b0, col_cur} + LW_W'(1);

    always_comb
    begin
        if (col_plus >= width_eff)
        begin
            column_count_next = '0;
            row_count_next    = (row_cur == ROW_W'(MAX_HEIGHT - 1)) ? '0
                                                                    : row_cur + ROW_W'(1);
        end
        else
        begin
            column_count_next = col_plus[COL_W-1:0];
            row_count_next    = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else if (accept)
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // stage 1: memory read data, forwarding, write-back
    assign up_eff         = fwd_valid_reg ? fwd_reg.upper : rd_reg.upper;
    assign lo_eff         = fwd_valid_reg ? fwd_reg.lower : rd_reg.lower;
    assign wr_entry.upper = lo_eff;
    assign wr_entry.lower = s1_reg.pix;

    assign mem_we = clearing || s1_leave;
    assign mem_wa = clearing ? clr_cnt_reg[COL_W-1:0] : s1_reg.col;
    assign mem_wd = clearing ? '0 : wr_entry;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[mem_wa] <= mem_wd;
        if (accept)
            rd_reg <= line_mem[col_cur];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (free1)
        begin
            s1_valid_reg <= accept;
            if (accept)
                fwd_valid_reg <= s1_valid_reg && (s1_reg.col == col_cur);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.pix <= {pix_in.red, pix_in.green, pix_in.blue};
            s1_reg.col <= col_cur;
            s1_reg.row <= row_cur;
            fwd_reg    <= wr_entry;
        end
    end

    // stage 2: window
    always_ff @(posedge clk)
    begin
        if (s1_leave)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= up_eff;
            win_reg[1][2] <= lo_eff;
            win_reg[2][2] <= s1_reg.pix;
            s2_col_reg    <= s1_reg.col - COL_W'(1);
            s2_row_reg    <= s1_reg.row - ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (free2)
            s2_valid_reg <= s1_valid_reg && (s1_reg.col >= COL_W'(2))
                            && (s1_reg.row >= ROW_W'(2));
    end

    // stage 3: per-channel sum and sum of squares
    always_comb
    begin
        logic [PIX_W-1:0]   v;
        logic [2*PIX_W-1:0] vsq;
        v   = '0;
        vsq = '0;
        for (int ch = 0; ch < CH_N; ch++)
        begin
            sum_comb[ch] = '0;
            sq_comb[ch]  = '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    v   = win_reg[r][c][ch*PIX_W +: PIX_W];
                    vsq = (2*PIX_W)'(v) * (2*PIX_W)'(v);
                    sum_comb[ch] = sum_comb[ch] + SUM_W'(v);
                    sq_comb[ch]  = sq_comb[ch] + SQ_W'(vsq);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free3 && s2_valid_reg)
        begin
            s3_sum_reg <= sum_comb;
            s3_sq_reg  <= sq_comb;
            s3_col_reg <= s2_col_reg;
            s3_row_reg <= s2_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (free3)
            s3_valid_reg <= s2_valid_reg;
    end

    // stage 4: 9*sum(x^2) - (sum x)^2 per channel
    always_comb
    begin
        logic [NQ_W-1:0] nine_q;
        logic [NQ_W-1:0] s_sq;
        nine_q = '0;
        s_sq   = '0;
        for (int ch = 0; ch < CH_N; ch++)
        begin
            nine_q = (NQ_W'(s3_sq_reg[ch]) << 3) + NQ_W'(s3_sq_reg[ch]);
            s_sq   = NQ_W'(s3_sum_reg[ch]) * NQ_W'(s3_sum_reg[ch]);
            ch_score_comb[ch] = CH_SCORE_W'(nine_q - s_sq);
        end
    end

    always_ff @(posedge clk)
    begin
        if (free4 && s3_valid_reg)
        begin
            s4_score_reg <= ch_score_comb;
            s4_col_reg   <= s3_col_reg;
            s4_row_reg   <= s3_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (free4)
            s4_valid_reg <= s3_valid_reg;
    end

    // stage 5: sum of the channel scores into the output register
    always_ff @(posedge clk)
    begin
        if (free5 && s4_valid_reg)
        begin
            res_score_reg <= SCORE_W'(s4_score_reg[0]) + SCORE_W'(s4_score_reg[1])
                             + SCORE_W'(s4_score_reg[2]);
            res_col_reg   <= s4_col_reg;
            res_row_reg   <= s4_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (free5)
            res_valid_reg <= s4_valid_reg;
    end

    assign res_out.valid             = res_valid_reg;
    assign res_out.spread_times_nine = res_score_reg;
    assign res_out.centre_column     = res_col_reg;
    assign res_out.centre_row        = res_row_reg;

    a_score_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_score_reg <= SCORE_W'(SCORE_MAX))
        else $error("score above maximum");

    a_centre_interior: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_col_reg != '0) && (res_row_reg != '0))
        else $error("score for an edge centre");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s1_valid_reg && !s2_valid_reg && !fwd_valid_reg)
        else $error("pipeline active during memory clear");

    a_fwd_needs_pred: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fwd_valid_reg) |-> $past(s1_valid_reg))
        else $error("forward without a preceding write");

endmodule
